// ===== rtl/core/ppbuf_pkg.sv =====
// Package for the ping-pong sample playback buffer.
// Holds the bank status codes, command codes, field widths and register map.
// No dependencies.
package ppbuf_pkg;

	localparam int DATA_W = 16;
	localparam int FLEN_W = 10;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [FLEN_W-1:0] FLEN_RESET = 10'd512;
	localparam logic [PADDR_W-1:0] REG_FRAME_LENGTH = 3'd0;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_WRITABLE = 2'd0,
		ST_FULL     = 2'd1,
		ST_READING  = 2'd2
	} bank_status_t;

endpackage

// ===== rtl/core/ppbuf_if.sv =====
// Valid/ready channel interfaces for the ping-pong sample playback buffer.
// Field widths come from ppbuf_pkg.
interface ppbuf_item_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [ppbuf_pkg::DATA_W-1:0] sample_value;

	modport source (output valid, output cmd, output sample_value, input ready);
	modport sink (input valid, input cmd, input sample_value, output ready);
endinterface

interface ppbuf_result_if;
	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic                       sample_valid;
	logic [ppbuf_pkg::DATA_W-1:0] out_sample;
	logic                       underrun;

	modport source (output valid, output accepted, output sample_valid, output out_sample,
		output underrun, input ready);
	modport sink (input valid, input accepted, input sample_valid, input out_sample,
		input underrun, output ready);
endinterface

// ===== rtl/core/ping_pong_sample_playback_buffer.sv =====
// Top level of the ping-pong sample playback buffer.
// Depends on ppbuf_pkg and the channel interfaces in ppbuf_if.sv.
//
// Usage: each beat on the item channel is either a sample write (cmd write)
// or a sample-clock tick (cmd tick). Writes fill bank A, then bank B; a bank
// turns full after frame_length samples. A tick starts reading a full bank
// when none is reading, hands out one sample per tick, and on the tick after
// the last sample returns the bank to writable with no sample. A tick with
// nothing to read sets underrun. Every item gives exactly one result beat.
// The accepting edge loads the bank memory read register; the result
// register, which presents the result beat, loads from it when it is empty
// or being taken.
// Throughput is one item per cycle; the single-port bank memory does one
// access per item. The item channel stays ready while the result register
// is empty or being taken, so a stalled receiver holds up input only once
// both internal registers are occupied.
// Reset clears the bank status, the offsets and pipeline valids, and sets
// frame_length to 512. Bank memory contents are undefined until written.
// frame_length is written through the APB port at address 0.
module ping_pong_sample_playback_buffer #(
	parameter int BANK_DEPTH = 512,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ppbuf_item_if.sink                      item,
	ppbuf_result_if.source                  result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppbuf_pkg::PADDR_W-1:0]   paddr,
	input  logic [ppbuf_pkg::PDATA_W-1:0]   pwdata,
	output logic [ppbuf_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	import ppbuf_pkg::*;

	localparam int OW = $clog2(BANK_DEPTH + 1);
	localparam int LW = (OW > FLEN_W) ? OW : FLEN_W;
	localparam int MAW = $clog2(2 * BANK_DEPTH);

	logic [SAMPLE_WIDTH-1:0] mem [2*BANK_DEPTH];

	logic [FLEN_W-1:0] flen_q;
	bank_status_t      a_st_q, b_st_q, a_st_d, b_st_d;
	logic [OW-1:0]     a_off_q, b_off_q, a_off_d, b_off_d;

	logic [LW-1:0]     eff_len;
	logic              acc_in, adv_s2;
	logic              mem_we, mem_re;
	logic [MAW-1:0]    waddr, raddr;
	logic              wr_b, rd_b;
	logic [OW-1:0]     woff, wpos, wnxt, roff;
	logic              acc_d, sv_d, ur_d;
	bank_status_t      a_pro, b_pro;

	logic                    v_s1, acc_s1, sv_s1, ur_s1;
	logic [SAMPLE_WIDTH-1:0] rd_s1;
	logic                    v_s2, acc_s2, sv_s2, ur_s2;
	logic [DATA_W-1:0]       smp_s2;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_FRAME_LENGTH) ? PDATA_W'(flen_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q <= FLEN_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_FRAME_LENGTH) begin
			flen_q <= pwdata[FLEN_W-1:0];
		end
	end

	always_comb begin
		if (flen_q == '0) begin
			eff_len = LW'(1);
		end else if (LW'(flen_q) > LW'(BANK_DEPTH)) begin
			eff_len = LW'(BANK_DEPTH);
		end else begin
			eff_len = LW'(flen_q);
		end
	end

	assign adv_s2 = !v_s2 || result.ready;
	assign item.ready = !v_s1 || adv_s2;
	assign acc_in = item.valid && item.ready;

	always_comb begin
		a_st_d = a_st_q;
		b_st_d = b_st_q;
		a_off_d = a_off_q;
		b_off_d = b_off_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		acc_d = 1'b0;
		sv_d = 1'b0;
		ur_d = 1'b0;
		a_pro = a_st_q;
		b_pro = b_st_q;

		wr_b = (a_st_q != ST_WRITABLE);
		woff = wr_b ? b_off_q : a_off_q;
		wpos = (LW'(woff) >= LW'(BANK_DEPTH)) ? OW'(BANK_DEPTH - 1) : woff;
		wnxt = wpos + OW'(1);
		waddr = wr_b ? MAW'(BANK_DEPTH) + MAW'(wpos) : MAW'(wpos);

		if (a_st_q != ST_READING && b_st_q != ST_READING) begin
			if (a_st_q == ST_FULL) begin
				a_pro = ST_READING;
			end else if (b_st_q == ST_FULL) begin
				b_pro = ST_READING;
			end
		end
		rd_b = (a_pro != ST_READING);
		roff = rd_b ? b_off_q : a_off_q;
		raddr = rd_b ? MAW'(BANK_DEPTH) + MAW'(roff) : MAW'(roff);

		if (item.cmd == CMD_WRITE) begin
			if (a_st_q == ST_WRITABLE || b_st_q == ST_WRITABLE) begin
				acc_d = 1'b1;
				mem_we = 1'b1;
				if (!wr_b) begin
					if (LW'(wnxt) >= eff_len) begin
						a_st_d = ST_FULL;
						a_off_d = '0;
					end else begin
						a_off_d = wnxt;
					end
				end else begin
					if (LW'(wnxt) >= eff_len) begin
						b_st_d = ST_FULL;
						b_off_d = '0;
					end else begin
						b_off_d = wnxt;
					end
				end
			end
		end else begin
			a_st_d = a_pro;
			b_st_d = b_pro;
			if (a_pro == ST_READING || b_pro == ST_READING) begin
				if (LW'(roff) >= eff_len) begin
					if (!rd_b) begin
						a_st_d = ST_WRITABLE;
						a_off_d = '0;
					end else begin
						b_st_d = ST_WRITABLE;
						b_off_d = '0;
					end
				end else begin
					sv_d = 1'b1;
					mem_re = 1'b1;
					if (!rd_b) begin
						a_off_d = roff + OW'(1);
					end else begin
						b_off_d = roff + OW'(1);
					end
				end
			end else begin
				ur_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_st_q <= ST_WRITABLE;
			b_st_q <= ST_WRITABLE;
			a_off_q <= '0;
			b_off_q <= '0;
		end else if (acc_in) begin
			a_st_q <= a_st_d;
			b_st_q <= b_st_d;
			a_off_q <= a_off_d;
			b_off_q <= b_off_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && mem_we) begin
			mem[waddr] <= item.sample_value[SAMPLE_WIDTH-1:0];
		end
		if (acc_in && mem_re) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (acc_in) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			acc_s1 <= acc_d;
			sv_s1 <= sv_d;
			ur_s1 <= ur_d;
		end
		if (adv_s2 && v_s1) begin
			acc_s2 <= acc_s1;
			sv_s2 <= sv_s1;
			ur_s2 <= ur_s1;
			smp_s2 <= sv_s1 ? DATA_W'(rd_s1) : '0;
		end
	end

	assign result.valid = v_s2;
	assign result.accepted = acc_s2;
	assign result.sample_valid = sv_s2;
	assign result.out_sample = smp_s2;
	assign result.underrun = ur_s2;

endmodule
